[rtl/core/isc_pkg.sv]
// Shared types, codes and helper functions of the integer field scanner.
`default_nettype none

package isc_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CMP_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // number_base register codes
    localparam logic [2:0] CFG_DEC  = 3'd0;
    localparam logic [2:0] CFG_OCT  = 3'd1;
    localparam logic [2:0] CFG_HEX  = 3'd2;
    localparam logic [2:0] CFG_BIN  = 3'd3;
    localparam logic [2:0] CFG_AUTO = 3'd4;

    // register indexes
    localparam logic REG_NUMBER_BASE = 1'b0;
    localparam logic REG_FIELD_WIDTH = 1'b1;

    // characters of interest
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;

    localparam logic [3:0] TEN = 4'd10;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2,
        BASE_BIN = 2'd3
    } base_t;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_LEAD   = 2'd1,
        PH_ZERO   = 2'd2,
        PH_DIGITS = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic               success;
        logic signed [63:0] value;
        logic [15:0]        consumed_count;
    } out_word_t;

    // classified character handed from front to back
    typedef struct packed {
        logic       eot;
        logic       is_sign;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
        logic       is_hex;
        logic [3:0] digit;
    } class_t;

    // finished field, sign applied at the output side
    typedef struct packed {
        logic        success;
        logic        negative;
        logic [63:0] magnitude;
        logic [15:0] count;
    } result_t;

    // back-end status seen by the top level
    typedef struct packed {
        logic   advance;
        logic   finish;
        phase_t phase;
    } back_status_t;

    function automatic base_t base_code(logic [2:0] cfg);
        base_t b;
        case (cfg)
            CFG_OCT: b = BASE_OCT;
            CFG_HEX: b = BASE_HEX;
            CFG_BIN: b = BASE_BIN;
            default: b = BASE_DEC;
        endcase
        return b;
    endfunction

    function automatic logic digit_fits(logic [3:0] d, base_t b);
        logic ok;
        case (b)
            BASE_DEC: ok = (d < TEN);
            BASE_OCT: ok = (d[3] == 1'b0);
            BASE_HEX: ok = 1'b1;
            BASE_BIN: ok = (d[3:1] == 3'd0);
            default:  ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [15:0] clip_count(logic [COUNT_BITS-1:0] c);
        logic [CMP_W-1:0] e;
        e = CMP_W'(c);
        if (e > CMP_W'(16'hFFFF))
            return 16'hFFFF;
        return e[15:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/isc_front.sv]
// Front end: classifies each input character and queues it for the back end.
`default_nettype none

module isc_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire isc_pkg::in_word_t item,
    output logic                   cls_valid,
    output isc_pkg::class_t        cls,
    input  wire logic              cls_pop
);

    isc_pkg::class_t cls_in;
    isc_pkg::class_t slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            do_push, do_pop;

    // classify
    always_comb
    begin
        cls_in          = '0;
        cls_in.eot      = item.end_of_text;
        cls_in.is_sign  = (item.char_code == isc_pkg::CH_MINUS) ||
                          (item.char_code == isc_pkg::CH_PLUS);
        cls_in.is_minus = (item.char_code == isc_pkg::CH_MINUS);
        cls_in.is_zero  = (item.char_code == isc_pkg::CH_ZERO);
        cls_in.is_x     = (item.char_code == isc_pkg::CH_X_LO) ||
                          (item.char_code == isc_pkg::CH_X_UP);
        if (item.char_code inside {[isc_pkg::CH_ZERO:isc_pkg::CH_NINE]})
        begin
            cls_in.is_hex = 1'b1;
            cls_in.digit  = 4'(item.char_code - isc_pkg::CH_ZERO);
        end
        else if (item.char_code inside {[isc_pkg::CH_A_LO:isc_pkg::CH_F_LO]})
        begin
            cls_in.is_hex = 1'b1;
            cls_in.digit  = 4'(item.char_code - isc_pkg::CH_A_LO) + isc_pkg::TEN;
        end
        else if (item.char_code inside {[isc_pkg::CH_A_UP:isc_pkg::CH_F_UP]})
        begin
            cls_in.is_hex = 1'b1;
            cls_in.digit  = 4'(item.char_code - isc_pkg::CH_A_UP) + isc_pkg::TEN;
        end
    end

    assign full      = (cnt_reg == 2'd2);
    assign cls_valid = (cnt_reg != 2'd0);
    assign cls       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cls_pop && cls_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= cls_in;
    end

endmodule

`default_nettype wire

[rtl/core/isc_back.sv]
// Back end: field state machine and shift-add accumulator.
`default_nettype none

module isc_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [2:0]          number_base,
    input  wire logic [15:0]         field_width,
    input  wire logic                cls_valid,
    input  wire isc_pkg::class_t     cls,
    output logic                     cls_pop,
    input  wire logic                res_full,
    output logic                     res_push,
    output isc_pkg::result_t         res,
    output isc_pkg::back_status_t    status
);

    localparam logic [isc_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    isc_pkg::phase_t phase_reg, phase_next;
    logic            neg_reg, neg_next;
    logic [63:0]     acc_reg, acc_next;
    isc_pkg::base_t  base_reg, base_next;
    logic            seen_reg, seen_next;
    logic [isc_pkg::COUNT_BITS-1:0] cnt_reg, cnt_next, cnt_inc;

    logic            advance, lead_phase, autodet;
    logic            sign_case, zero_case, x_case, digit_case, digit_ok;
    logic            consume, width_hit, finish;
    isc_pkg::base_t  cfg_base, sel_base;
    logic [63:0]     mac;
    logic            upd_neg, upd_seen;
    logic [63:0]     upd_acc;
    isc_pkg::base_t  upd_base;
    logic [isc_pkg::COUNT_BITS-1:0] upd_cnt;

    assign advance = cls_valid && !res_full;
    assign cls_pop = advance;

    // decode the character against the current phase
    always_comb
    begin
        lead_phase = (phase_reg == isc_pkg::PH_START) || (phase_reg == isc_pkg::PH_LEAD);
        autodet    = (number_base == isc_pkg::CFG_AUTO);
        cfg_base   = isc_pkg::base_code(number_base);
        sel_base   = lead_phase ? cfg_base : base_reg;
        sign_case  = !cls.eot && (phase_reg == isc_pkg::PH_START) && cls.is_sign;
        zero_case  = !cls.eot && !sign_case && lead_phase && cls.is_zero &&
                     (autodet || cfg_base == isc_pkg::BASE_HEX);
        x_case     = !cls.eot && (phase_reg == isc_pkg::PH_ZERO) && cls.is_x;
        digit_case = !cls.eot && !sign_case && !zero_case && !x_case;
        digit_ok   = cls.is_hex && isc_pkg::digit_fits(cls.digit, sel_base);
        consume    = sign_case || zero_case || x_case || (digit_case && digit_ok);
        cnt_inc    = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
        width_hit  = consume && (field_width != 16'd0) &&
                     (isc_pkg::CMP_W'(cnt_inc) >= isc_pkg::CMP_W'(field_width));
        finish     = cls.eot || (digit_case && !digit_ok) || width_hit;
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            if (finish)
                phase_next = isc_pkg::PH_START;
            else if (sign_case)
                phase_next = isc_pkg::PH_LEAD;
            else if (zero_case)
                phase_next = isc_pkg::PH_ZERO;
            else
                phase_next = isc_pkg::PH_DIGITS;
        end
    end

    // datapath and result
    always_comb
    begin
        if (sel_base == isc_pkg::BASE_DEC)
            mac = (acc_reg << 3) + (acc_reg << 1) + 64'(cls.digit);
        else if (sel_base == isc_pkg::BASE_OCT)
            mac = (acc_reg << 3) | 64'(cls.digit);
        else if (sel_base == isc_pkg::BASE_HEX)
            mac = (acc_reg << 4) | 64'(cls.digit);
        else
            mac = (acc_reg << 1) | 64'(cls.digit);

        upd_neg  = sign_case ? cls.is_minus : neg_reg;
        upd_acc  = acc_reg;
        upd_seen = seen_reg;
        upd_base = base_reg;
        upd_cnt  = consume ? cnt_inc : cnt_reg;
        if (zero_case)
        begin
            upd_acc  = 64'd0;
            upd_seen = 1'b1;
            upd_base = autodet ? isc_pkg::BASE_OCT : cfg_base;
        end
        else if (x_case)
        begin
            upd_seen = 1'b0;
            upd_base = isc_pkg::BASE_HEX;
        end
        else if (digit_case)
        begin
            upd_base = sel_base;
            if (digit_ok)
            begin
                upd_acc  = mac;
                upd_seen = 1'b1;
            end
        end

        res_push      = advance && finish;
        res.success   = upd_seen;
        res.negative  = upd_neg;
        res.magnitude = upd_seen ? upd_acc : 64'd0;
        res.count     = upd_seen ? isc_pkg::clip_count(upd_cnt) : 16'd0;

        neg_next  = neg_reg;
        acc_next  = acc_reg;
        base_next = base_reg;
        seen_next = seen_reg;
        cnt_next  = cnt_reg;
        if (advance)
        begin
            if (finish)
            begin
                neg_next  = 1'b0;
                acc_next  = 64'd0;
                base_next = isc_pkg::BASE_DEC;
                seen_next = 1'b0;
                cnt_next  = '0;
            end
            else
            begin
                neg_next  = upd_neg;
                acc_next  = upd_acc;
                base_next = upd_base;
                seen_next = upd_seen;
                cnt_next  = upd_cnt;
            end
        end
    end

    assign status.advance = advance;
    assign status.finish  = finish;
    assign status.phase   = phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= isc_pkg::PH_START;
            neg_reg   <= 1'b0;
            acc_reg   <= 64'd0;
            base_reg  <= isc_pkg::BASE_DEC;
            seen_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            seen_reg  <= seen_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/isc_out.sv]
// Result queue: holds finished fields and applies the sign on the way out.
`default_nettype none

module isc_out (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               res_push,
    input  wire isc_pkg::result_t   res,
    output logic                    res_full,
    output logic                    empty,
    input  wire logic               pop,
    output isc_pkg::out_word_t      result
);

    isc_pkg::result_t slot_reg [2];
    isc_pkg::result_t head;
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;
    assign head     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        result.success        = head.success;
        result.value          = head.negative ? -$signed(head.magnitude)
                                              : $signed(head.magnitude);
        result.consumed_count = head.count;
    end

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= res;
    end

endmodule

`default_nettype wire

[rtl/core/integer_field_scanner_core.sv]
// Top level of the integer field scanner: config registers, front, back and result queue.
//
// Usage:
//   Input words (item) carry one text byte and an end_of_text flag. A word is taken
//   at a clock edge with push high and full low. A field is an optional sign, an
//   optional 0x prefix (hex and auto-detect), then digits of the configured base.
//   Each finished field leaves one result word (success, value, consumed_count) in
//   the result queue; it is shown while empty is low and removed on pop.
//   The character that ends a field is dropped; end_of_text always closes a field.
//   Configuration: wr_en/wr_index/wr_data write number_base (index 0) and
//   field_width (index 1); write them only while the block is idle.
// Timing:
//   One character per cycle while the result queue has room. A taken word waits
//   in the input queue until the back end steps on it; the result of a closing word
//   is registered in the result queue, shown on the result ports, and can then be
//   popped. Both queues are two words deep; a stalled receiver fills the result
//   queue, then the back end holds, then full rises. No word is lost.
// Reset:
//   rst_n clears both queues, the field state and the registers (decimal base,
//   no width limit).
`default_nettype none

module integer_field_scanner_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire isc_pkg::in_word_t  item,
    output logic                    empty,
    input  wire logic               pop,
    output isc_pkg::out_word_t      result,
    input  wire logic               wr_en,
    input  wire logic               wr_index,
    input  wire logic [15:0]        wr_data
);

    logic [2:0]  number_base_reg;
    logic [15:0] field_width_reg;

    logic                  cls_valid;
    logic                  cls_pop;
    isc_pkg::class_t       cls;
    logic                  res_full;
    logic                  res_push;
    isc_pkg::result_t      res;
    isc_pkg::back_status_t status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= isc_pkg::CFG_DEC;
            field_width_reg <= 16'd0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                isc_pkg::REG_NUMBER_BASE: number_base_reg <= wr_data[2:0];
                isc_pkg::REG_FIELD_WIDTH: field_width_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // classify and queue incoming characters
    isc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cls_valid (cls_valid),
        .cls       (cls),
        .cls_pop   (cls_pop)
    );

    // advance the field state one character at a time
    isc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .number_base (number_base_reg),
        .field_width (field_width_reg),
        .cls_valid   (cls_valid),
        .cls         (cls),
        .cls_pop     (cls_pop),
        .res_full    (res_full),
        .res_push    (res_push),
        .res         (res),
        .status      (status)
    );

    // hold finished fields for the receiver
    isc_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    // the back end never steps while the result queue has no room
    a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        status.advance |-> !res_full)
        else $error("back end stepped with result queue full");

    // a closed field restarts from the start phase
    a_restart_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (status.advance && status.finish) |=> (status.phase == isc_pkg::PH_START))
        else $error("field did not restart after result");

    // a failed field reports zero value and zero count
    a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !res.success) |-> (res.magnitude == 64'd0 && res.count == 16'd0))
        else $error("failed field carries data");

    // a converted field consumed at least one character
    a_success_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.success) |-> (res.count != 16'd0))
        else $error("successful field with zero count");

endmodule

`default_nettype wire
